@@ hdl/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg
// Types, constants and helper functions shared by the matrix scanner modules.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int unsigned MOD_ROW  = 6;
  localparam logic [7:0]  MOD_MASK = 8'h17;  // shift, ctrl and two more modifiers
  localparam logic [2:0]  CAPS_COL = 3'd3;
  localparam logic [2:0]  SHIFT_COL = 3'd0;
  localparam logic [2:0]  CTRL_COL  = 3'd1;

  typedef struct packed {
    logic [3:0] row_index;
    logic [7:0] row_bits;
  } kms_row_t;

  typedef struct packed {
    logic [3:0] key_row;
    logic [2:0] key_col;
    logic       shift_held;
    logic       ctrl_held;
    logic       caps_on;
    logic       is_repeat;
  } kms_result_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

  // index of the highest set bit; zero when none
  function automatic logic [2:0] top_bit8(input logic [7:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 3'(i);
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/kms_core.sv @@
// ----------------------------------------------------------------------------
// kms_core
// Scan state and per-row update: edge detect, key count, newest press,
// repeat timer and caps lock. One row per enabled cycle.
// ----------------------------------------------------------------------------
module kms_core import kms_pkg::*; #(
  parameter int ROWS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  kms_row_t    row,
  input  logic [7:0]  first_delay,
  input  logic [7:0]  repeat_delay,
  output logic        res_valid,
  output kms_result_t res
);

  localparam int  RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam bit  HAS_MOD = (ROWS > MOD_ROW);

  logic [7:0] prev_rows [ROWS];
  logic [6:0] keys_down;
  logic [7:0] repeat_timer;
  logic       fresh_press;
  logic [3:0] last_row;
  logic [2:0] last_col;
  logic       caps_state;

  logic [6:0] keys_down_next;
  logic [7:0] repeat_timer_next;
  logic       fresh_press_next;
  logic [3:0] last_row_next;
  logic [2:0] last_col_next;
  logic       caps_state_next;

  logic          in_range, is_last, is_mod_row;
  logic [RW-1:0] ridx;
  logic [7:0]    old_bits, change, mods, rise, fall;
  logic [7:0]    mod_row_cur, mod_row_new;
  logic [7:0]    t1, t_dec;
  logic          emit, emit_repeat, caps_hit;

  assign ridx       = row.row_index[RW-1:0];
  assign in_range   = ({1'b0, row.row_index} < 5'(ROWS));
  assign is_last    = (row.row_index == 4'(ROWS - 1));
  assign is_mod_row = HAS_MOD && (row.row_index == 4'(MOD_ROW));

  generate
    if (HAS_MOD) begin : g_mod
      assign mod_row_cur = prev_rows[MOD_ROW];
    end else begin : g_nomod
      assign mod_row_cur = '0;
    end
  endgenerate

  always_comb begin
    old_bits = in_range ? prev_rows[ridx] : '0;
    change   = row.row_bits ^ old_bits;
    mods     = is_mod_row ? MOD_MASK : '0;
    rise     = change & ~old_bits & ~mods;
    fall     = change & old_bits & ~mods;
    mod_row_new = is_mod_row ? row.row_bits : mod_row_cur;

    keys_down_next = keys_down + 7'(popcount8(rise)) - 7'(popcount8(fall));
    fresh_press_next = fresh_press;
    last_row_next    = last_row;
    last_col_next    = last_col;
    if (rise != '0) begin
      fresh_press_next = 1'b1;
      last_row_next    = row.row_index;
      last_col_next    = top_bit8(rise);
    end

    t1 = ((change & mods) != '0) ? first_delay : repeat_timer;
    t_dec = t1 - 8'd1;
    repeat_timer_next = t1;
    emit        = 1'b0;
    emit_repeat = 1'b0;
    if (is_last) begin
      if (keys_down_next != '0) begin
        if (fresh_press_next) begin
          emit = 1'b1;
          repeat_timer_next = first_delay;
        end else if (t_dec == '0) begin
          emit = 1'b1;
          emit_repeat = 1'b1;
          repeat_timer_next = repeat_delay;
        end else begin
          repeat_timer_next = t_dec;
        end
      end
      fresh_press_next = 1'b0;
    end

    caps_hit = HAS_MOD && (last_row_next == 4'(MOD_ROW)) && (last_col_next == CAPS_COL);
    caps_state_next = caps_state ^ (emit & caps_hit);

    res_valid      = step && in_range && emit && !caps_hit;
    res.key_row    = last_row_next;
    res.key_col    = last_col_next;
    res.shift_held = mod_row_new[SHIFT_COL];
    res.ctrl_held  = mod_row_new[CTRL_COL];
    res.caps_on    = caps_state;
    res.is_repeat  = emit_repeat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        prev_rows[i] <= '0;
      end
      keys_down    <= '0;
      repeat_timer <= '0;
      fresh_press  <= 1'b0;
      last_row     <= '0;
      last_col     <= '0;
      caps_state   <= 1'b0;
    end else if (step && in_range) begin
      prev_rows[ridx] <= row.row_bits;
      keys_down    <= keys_down_next;
      repeat_timer <= repeat_timer_next;
      fresh_press  <= fresh_press_next;
      last_row     <= last_row_next;
      last_col     <= last_col_next;
      caps_state   <= caps_state_next;
    end
  end

endmodule

@@ hdl/kms_out_stage.sv @@
// ----------------------------------------------------------------------------
// kms_out_stage
// Result register toward the receiver; frees up when empty or being taken.
// ----------------------------------------------------------------------------
module kms_out_stage import kms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  kms_result_t res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output kms_result_t out_res
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_res <= res;
    end
  end

endmodule

@@ hdl/key_matrix_scan_autorepeat.sv @@
// ----------------------------------------------------------------------------
// key_matrix_scan_autorepeat
// Keyboard matrix scanner with key counting and auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, row_index, row_bits): one matrix row per
//   item, rows 0 to ROWS-1 in order each scan. Rows at or above ROWS are
//   dropped without effect.
//   Output channel (out_valid/out_stall, key_* fields): at most one item per
//   scan, produced by the last row: a fresh press, or a repeat when the scan
//   tick timer runs out. The caps key toggles caps_on and reports nothing.
//   APB port: first_delay at 0x0, repeat_delay at 0x4 (8 bits each, zero
//   means 256 ticks). Write only while the block is idle.
// Timing:
//   One item per cycle sustained while the receiver does not stall. An item
//   waits in the input register and is processed into the result register
//   when the result register is free; the receiver takes it from there.
//   While the receiver stalls a held result, the stage behind it stops and
//   in_stall rises once the input register is full; nothing is lost.
// Reset (rst, synchronous): clears all stored rows, count, timer and caps;
//   delays return to 25 and 5.
// ----------------------------------------------------------------------------
module key_matrix_scan_autorepeat import kms_pkg::*; #(
  parameter int ROWS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  row_index,
  input  logic [7:0]  row_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  key_row,
  output logic [2:0]  key_col,
  output logic        shift_held,
  output logic        ctrl_held,
  output logic        caps_on,
  output logic        is_repeat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FIRST_DELAY  = 1'b0;
  localparam logic REG_REPEAT_DELAY = 1'b1;

  logic [7:0]  first_delay, repeat_delay;
  logic        in_full;
  kms_row_t    in_row;
  logic        out_free, step, res_valid;
  kms_result_t res, out_res;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay  <= 8'd25;
      repeat_delay <= 8'd5;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FIRST_DELAY:  first_delay  <= pwdata[7:0];
        REG_REPEAT_DELAY: repeat_delay <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_DELAY:  prdata = {24'd0, first_delay};
      REG_REPEAT_DELAY: prdata = {24'd0, repeat_delay};
      default:          prdata = '0;
    endcase
  end

  // input register
  assign step     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_row.row_index <= row_index;
      in_row.row_bits  <= row_bits;
    end
  end

  kms_core #(.ROWS(ROWS)) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .row          (in_row),
    .first_delay  (first_delay),
    .repeat_delay (repeat_delay),
    .res_valid    (res_valid),
    .res          (res)
  );

  kms_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign key_row    = out_res.key_row;
  assign key_col    = out_res.key_col;
  assign shift_held = out_res.shift_held;
  assign ctrl_held  = out_res.ctrl_held;
  assign caps_on    = out_res.caps_on;
  assign is_repeat  = out_res.is_repeat;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyboard matrix scanner with auto-repeat.
// Streams matrix scans, mostly in order with held keys and random presses,
// plus out-of-range rows and lone rows, under several delay settings and
// idling patterns. A scoreboard tracks the scan state and queues the key
// reports each row should produce, and checks every report the block emits.
// ----------------------------------------------------------------------------
module testbench;
  import kms_pkg::*;

  localparam int          ROWS              = 11;
  localparam logic [3:0]  LAST_ROW          = 4'(ROWS - 1);
  localparam logic [2:0]  ADDR_FIRST_DELAY  = 3'h0;
  localparam logic [2:0]  ADDR_REPEAT_DELAY = 3'h4;
  localparam int          LONG_HOLD         = 80;
  localparam int          SETTLE_CYCLES     = 6;
  localparam int          WATCHDOG_LIMIT    = 4000;

  class key_scoreboard;
    logic [7:0]  rows_seen [ROWS];
    logic [6:0]  held_count;
    logic [7:0]  tick_timer;
    bit          fresh;
    logic [3:0]  newest_row;
    logic [2:0]  newest_col;
    bit          caps;
    logic [7:0]  first_delay;
    logic [7:0]  repeat_delay;
    kms_result_t due_keys [$];
    int errors;
    int rows_taken;
    int rows_ignored;
    int keys_checked;
    int repeats_checked;
    int caps_toggles;

    function new();
      foreach (rows_seen[i]) rows_seen[i] = '0;
      held_count   = '0;
      tick_timer   = '0;
      fresh        = 0;
      newest_row   = '0;
      newest_col   = '0;
      caps         = 0;
      first_delay  = 8'd25;
      repeat_delay = 8'd5;
    endfunction

    function void set_delay(logic [2:0] addr, logic [7:0] value);
      if (addr == ADDR_FIRST_DELAY) begin
        first_delay = value;
      end else if (addr == ADDR_REPEAT_DELAY) begin
        repeat_delay = value;
      end
    endfunction

    // caps key toggles the lock instead of reporting
    function void report_newest(bit by_repeat);
      kms_result_t k;
      if (newest_row == MOD_ROW && newest_col == CAPS_COL) begin
        caps = ~caps;
        caps_toggles++;
        return;
      end
      k.key_row    = newest_row;
      k.key_col    = newest_col;
      k.shift_held = rows_seen[MOD_ROW][SHIFT_COL];
      k.ctrl_held  = rows_seen[MOD_ROW][CTRL_COL];
      k.caps_on    = caps;
      k.is_repeat  = by_repeat;
      due_keys.push_back(k);
    endfunction

    function void note_row(logic [3:0] r, logic [7:0] bits);
      logic [7:0] old_bits;
      logic [7:0] delta;
      logic [7:0] mods;
      if (r >= ROWS) begin
        rows_ignored++;
        return;
      end
      rows_taken++;
      old_bits = rows_seen[r];
      delta    = bits ^ old_bits;
      mods     = (r == MOD_ROW) ? MOD_MASK : 8'h00;
      if ((delta & mods) != 8'h00) tick_timer = first_delay;
      for (int n = 0; n < 8; n++) begin
        if (delta[n] && !mods[n]) begin
          if (old_bits[n]) begin
            held_count--;
          end else begin
            held_count++;
            fresh      = 1;
            newest_row = r;
            newest_col = 3'(n);
          end
        end
      end
      rows_seen[r] = bits;
      if (r == LAST_ROW) begin
        if (held_count != 0) begin
          if (fresh) begin
            report_newest(0);
            tick_timer = first_delay;
          end else begin
            tick_timer--;
            if (tick_timer == 0) begin
              report_newest(1);
              tick_timer = repeat_delay;
            end
          end
        end
        fresh = 0;
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_key(kms_result_t got);
      kms_result_t want;
      if (due_keys.size() == 0) begin
        $error("key report with none due: row %0d col %0d", got.key_row, got.key_col);
        errors++;
        return;
      end
      want = due_keys.pop_front();
      keys_checked++;
      if (got.is_repeat) repeats_checked++;
      compare_field("key_row", want.key_row, got.key_row);
      compare_field("key_col", want.key_col, got.key_col);
      compare_field("shift_held", want.shift_held, got.shift_held);
      compare_field("ctrl_held", want.ctrl_held, got.ctrl_held);
      compare_field("caps_on", want.caps_on, got.caps_on);
      compare_field("is_repeat", want.is_repeat, got.is_repeat);
    endfunction

    function int pending();
      return due_keys.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [3:0]  row_index = '0;
  logic [7:0]  row_bits  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  key_row;
  logic [2:0]  key_col;
  logic        shift_held;
  logic        ctrl_held;
  logic        caps_on;
  logic        is_repeat;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  key_scoreboard sb;
  logic [7:0] pressed_rows [ROWS];
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  key_matrix_scan_autorepeat #(.ROWS(ROWS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_row    (key_row),
    .key_col    (key_col),
    .shift_held (shift_held),
    .ctrl_held  (ctrl_held),
    .caps_on    (caps_on),
    .is_repeat  (is_repeat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_row(row_index, row_bits);
    if (!rst && out_valid && !out_stall) begin
      sb.check_key('{key_row, key_col, shift_held, ctrl_held, caps_on, is_repeat});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_row(input logic [3:0] r, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_index <= r;
    row_bits  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending, let every due report arrive, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_delay(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly whole scans with held keys; some lone rows, skipped rows and
  // out-of-range rows mixed in
  task automatic run_scans(input int n_rows);
    int sent;
    int r;
    sent = 0;
    while (sent < n_rows) begin
      if ($urandom_range(99) < 5) begin
        r = $urandom_range(ROWS - 1);
        pressed_rows[r] = 8'($urandom_range(255));
        send_row(4'(r), pressed_rows[r]);
        sent++;
      end else begin
        if ($urandom_range(15) == 0) begin
          foreach (pressed_rows[i]) pressed_rows[i] = '0;
        end
        for (r = 0; r < ROWS; r++) begin
          if ($urandom_range(59) == 0) begin
            pressed_rows[r] = 8'($urandom_range(255));
          end else begin
            for (int k = 0; k < 8; k++) begin
              if ($urandom_range(r == MOD_ROW ? 11 : 63) == 0) begin
                pressed_rows[r][k] = ~pressed_rows[r][k];
              end
            end
          end
          if ($urandom_range(99) < 3) begin
            send_row(4'(ROWS + $urandom_range(15 - ROWS)), 8'($urandom_range(255)));
          end
          if ($urandom_range(49) != 0) begin
            send_row(4'(r), pressed_rows[r]);
            sent++;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] fd, input logic [7:0] rd, input int snd,
                           input int rcv, input int n_rows, input bit with_hold);
    drain();
    write_reg(ADDR_FIRST_DELAY, fd);
    write_reg(ADDR_REPEAT_DELAY, rd);
    send_idle_pct = snd;
    stall_pct     = rcv;
    if (with_hold) begin
      run_scans(n_rows / 2);
      hold_requests++;
      run_scans(n_rows - n_rows / 2);
    end else begin
      run_scans(n_rows);
    end
  endtask

  initial begin
    sb = new();
    foreach (pressed_rows[i]) pressed_rows[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 24;
    stall_pct     = 45;

    // reset delays: fresh presses, newest-key choice, caps, ignored rows
    send_row(4'd0, 8'hFF);
    send_row(LAST_ROW, 8'h80);
    send_row(4'hF, 8'hFF);
    send_row(4'(ROWS), 8'h00);
    send_row(4'(MOD_ROW), 8'h08);
    send_row(LAST_ROW, 8'h80);
    send_row(4'(MOD_ROW), 8'h09);
    send_row(4'd3, 8'h01);
    send_row(LAST_ROW, 8'h80);
    send_row(4'd0, 8'h00);
    send_row(4'd3, 8'h00);
    send_row(4'(MOD_ROW), 8'h00);
    send_row(LAST_ROW, 8'h00);
    send_row(LAST_ROW, 8'h00);   // nothing down: timer holds, no report

    // short delays: repeats and a modifier change restarting the timer
    drain();
    write_reg(ADDR_FIRST_DELAY, 8'd2);
    write_reg(ADDR_REPEAT_DELAY, 8'd1);
    send_row(4'd5, 8'h10);
    send_row(LAST_ROW, 8'h00);
    repeat (3) send_row(LAST_ROW, 8'h00);
    send_row(4'(MOD_ROW), 8'h02);
    repeat (2) send_row(LAST_ROW, 8'h00);
    send_row(4'd5, 8'h00);
    send_row(LAST_ROW, 8'h00);

    run_phase(8'd1,   8'd1,   24, 45, 450, 1);
    run_phase(8'd6,   8'd2,   24, 45, 400, 0);
    run_phase(8'd255, 8'd0,   45, 24, 300, 0);
    run_phase(8'd0,   8'd255, 45, 24, 300, 0);
    run_phase(8'd4,   8'd3,   0,  0,  400, 1);

    drain();
    if (sb.pending() != 0) begin
      $error("%0d key reports never arrived", sb.pending());
      sb.errors++;
    end
    $display("Scanned %0d rows (%0d out of range dropped) across seven delay settings.",
             sb.rows_taken, sb.rows_ignored);
    $display("Checked %0d key reports, %0d of them repeats; caps lock toggled %0d times.",
             sb.keys_checked, sb.repeats_checked, sb.caps_toggles);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/kms_pkg.sv
hdl/kms_core.sv
hdl/kms_out_stage.sv
hdl/key_matrix_scan_autorepeat.sv
bench/testbench.sv
